>>> src/fifo_queue_with_search_reverse_core_assert.svh
// Assertion macros used by the queue datapath.
// Both macros sample on i_clk and stay quiet while i_rst_n is low.
`ifndef FIFO_QUEUE_WITH_SEARCH_REVERSE_CORE_ASSERT_SVH
`define FIFO_QUEUE_WITH_SEARCH_REVERSE_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define FQSR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FQSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> src/fqsr_pkg.sv
// Shared constants and types of the queue with search and reverse.
// Used by the controller, the datapath and the top level; depends on nothing.
package fqsr_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam int KIND_W  = 3;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    localparam logic [KIND_W-1:0] OP_ENQ     = 3'd0;
    localparam logic [KIND_W-1:0] OP_DEQ     = 3'd1;
    localparam logic [KIND_W-1:0] OP_SEARCH  = 3'd2;
    localparam logic [KIND_W-1:0] OP_REVERSE = 3'd3;
    localparam logic [KIND_W-1:0] OP_CLEAR   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic enq;
        logic set_full;
        logic deq_rd;
        logic deq_cap;
        logic set_empty;
        logic scan_rd;
        logic rev;
        logic clr;
        logic res_ld;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              empty;
        logic              full;
        logic              scan_end;
        logic              out_free;
    } t_sts;

endpackage

>>> src/fqsr_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package dependency.
module fqsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/fqsr_ctrl.sv
// Controller of the queue: sequences one request at a time through the datapath.
// Depends on fqsr_pkg for the command and status types and the operation codes.
module fqsr_ctrl
    import fqsr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_DEQW   = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_cmd       cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                unique case (i_sts.kind)
                    OP_ENQ: begin
                        if (i_sts.full) begin
                            cmd.set_full = 1'b1;
                        end else begin
                            cmd.enq = 1'b1;
                        end
                    end
                    OP_DEQ: begin
                        if (i_sts.empty) begin
                            cmd.set_empty = 1'b1;
                        end else begin
                            cmd.deq_rd = 1'b1;
                            n_state    = S_DEQW;
                        end
                    end
                    OP_SEARCH:  n_state = S_SCAN;
                    OP_REVERSE: cmd.rev = 1'b1;
                    OP_CLEAR:   cmd.clr = 1'b1;
                    default:    n_state = S_DONE;
                endcase
            end
            S_DEQW: begin
                cmd.deq_cap = 1'b1;
                n_state     = S_DONE;
            end
            S_SCAN: begin
                // The last compare happens in the cycle that sees the end.
                if (i_sts.scan_end) begin
                    n_state = S_DONE;
                end else begin
                    cmd.scan_rd = 1'b1;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    cmd.res_ld = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_cmd      = cmd;

endmodule

>>> src/fqsr_dp.sv
// Datapath of the queue: ring pointers, direction flag, element RAM, search
// compare and the output register. Depends on fqsr_pkg, fqsr_ram and the assertion header.
`include "fifo_queue_with_search_reverse_core_assert.svh"

module fqsr_dp
    import fqsr_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    output t_sts                      o_sts,
    input  logic [KIND_W-1:0]         i_kind,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic                      i_out_stall,
    output logic                      o_out_valid,
    output logic signed [VALUE_W-1:0] o_result_value,
    output logic                      o_found,
    output logic [STAT_W-1:0]         o_status,
    output logic [COUNT_W-1:0]        o_count_after
);

    // Ring addition of two in-range indexes: one compare and subtract.
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                  input logic [IDX_W-1:0] b);
        logic [IDX_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (IDX_W + 1)'(DEPTH)) begin
            sum = sum - (IDX_W + 1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    logic [IDX_W-1:0]   r_head;
    logic [CNT_W-1:0]   r_count;
    logic               r_rev;
    logic [CNT_W-1:0]   r_idx;
    logic               r_rd_pend;
    logic               r_out_valid;

    logic [KIND_W-1:0]  r_kind;
    logic [VALUE_W-1:0] r_value;
    logic [VALUE_W-1:0] r_res_value;
    logic               r_found;
    logic [STAT_W-1:0]  r_status;
    logic [VALUE_W-1:0] r_out_value;
    logic               r_out_found;
    logic [STAT_W-1:0]  r_out_status;
    logic [COUNT_W-1:0] r_out_count;

    logic [IDX_W-1:0]   head_dec;
    logic [IDX_W-1:0]   enq_addr;
    logic [IDX_W-1:0]   deq_addr;
    logic [IDX_W-1:0]   scan_addr;
    logic [IDX_W-1:0]   raddr;
    logic [VALUE_W-1:0] rdata;

    assign head_dec  = ring_add(r_head, IDX_W'(DEPTH - 1));
    assign enq_addr  = r_rev ? head_dec : ring_add(r_head, r_count[IDX_W-1:0]);
    assign deq_addr  = r_rev ? ring_add(r_head, r_count[IDX_W-1:0] - IDX_W'(1)) : r_head;
    assign scan_addr = ring_add(r_head, r_idx[IDX_W-1:0]);
    assign raddr     = i_cmd.deq_rd ? deq_addr : scan_addr;

    fqsr_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.enq),
        .i_waddr (enq_addr),
        .i_wdata (r_value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_rev       <= 1'b0;
            r_idx       <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_pend <= i_cmd.scan_rd;
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.scan_rd) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (i_cmd.enq) begin
                r_count <= r_count + CNT_W'(1);
                if (r_rev) begin
                    r_head <= head_dec;
                end
            end else if (i_cmd.deq_rd) begin
                r_count <= r_count - CNT_W'(1);
                if (!r_rev) begin
                    r_head <= ring_add(r_head, IDX_W'(1));
                end
            end else if (i_cmd.rev) begin
                r_rev <= ~r_rev;
            end else if (i_cmd.clr) begin
                r_head  <= '0;
                r_count <= '0;
                r_rev   <= 1'b0;
            end
            if (i_cmd.res_ld) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request payload, per-request result and output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind      <= i_kind;
            r_value     <= i_value;
            r_res_value <= '0;
            r_found     <= 1'b0;
            r_status    <= ST_OK;
        end else begin
            if (r_rd_pend && (rdata == r_value)) begin
                r_found <= 1'b1;
            end
            if (i_cmd.deq_cap) begin
                r_res_value <= rdata;
            end
            if (i_cmd.set_full) begin
                r_status <= ST_FULL;
            end else if (i_cmd.set_empty) begin
                r_status <= ST_EMPTY;
            end
        end
        if (i_cmd.res_ld) begin
            r_out_value  <= r_res_value;
            r_out_found  <= r_found;
            r_out_status <= r_status;
            r_out_count  <= COUNT_W'(r_count);
        end
    end

    assign o_sts.kind     = r_kind;
    assign o_sts.empty    = (r_count == '0);
    assign o_sts.full     = (r_count == CNT_W'(DEPTH));
    assign o_sts.scan_end = (r_idx == r_count);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_found        = r_out_found;
    assign o_status       = r_out_status;
    assign o_count_after  = r_out_count;

    `FQSR_ASSERT_SAME(a_count_range, 1'b1, r_count <= CNT_W'(DEPTH), "count above depth")
    `FQSR_ASSERT_SAME(a_enq_not_full, i_cmd.enq, r_count != CNT_W'(DEPTH), "write into full queue")
    `FQSR_ASSERT_SAME(a_deq_not_empty, i_cmd.deq_rd, r_count != '0, "read from empty queue")
    `FQSR_ASSERT_SAME(a_cap_after_read, i_cmd.deq_cap, $past(i_cmd.deq_rd), "capture without read")
    `FQSR_ASSERT_NEXT(a_clear_state, i_cmd.clr, (r_count == '0) && (r_head == '0) && !r_rev, "clear left state")

endmodule

>>> src/fifo_queue_with_search_reverse_core.sv
// Queue of signed 32-bit values in a 16-entry ring RAM with search and reverse.
// One request at a time. Enqueue, reverse, clear and unused codes go through
// the decode and done states; dequeue adds a read wait state and search a scan
// state. The result is registered at the output as the controller goes idle.
// Search sweeps the single RAM read port one entry a cycle; output stalls hold done.
// Synchronous active-low reset empties the queue; RAM contents are not cleared.
module fifo_queue_with_search_reverse_core
    import fqsr_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [KIND_W-1:0]         i_kind,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [VALUE_W-1:0] o_result_value,
    output logic                      o_found,
    output logic [STAT_W-1:0]         o_status,
    output logic [COUNT_W-1:0]        o_count_after
);

    t_cmd cmd;
    t_sts sts;

    fqsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fqsr_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_kind         (i_kind),
        .i_value        (i_value),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_result_value (o_result_value),
        .o_found        (o_found),
        .o_status       (o_status),
        .o_count_after  (o_count_after)
    );

endmodule
